// ===== sv/dcdt_pkg.sv =====
// dcdt_pkg: types, codes and constants shared by the channel demux table.
// Depends on nothing; every other file of the block imports it.
package dcdt_pkg;

  // sizes
  localparam int unsigned TableEntriesDefault = 20;
  localparam int unsigned QueueDepthDefault   = 2;

  // request kinds
  localparam logic [1:0] KIND_REGISTER = 2'd0;
  localparam logic [1:0] KIND_PDU      = 2'd1;
  localparam logic [1:0] KIND_SEND     = 2'd2;

  // received header commands
  localparam logic [3:0] CMD_CREATE = 4'h1;
  localparam logic [3:0] CMD_DATA   = 4'h3;
  localparam logic [3:0] CMD_CLOSE  = 4'h4;
  localparam logic [3:0] CMD_CAPS   = 4'h5;

  // id width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_UNHANDLED = 3'd4;

  // action codes
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_CAPS     = 3'd1;
  localparam logic [2:0] ACT_GRANT    = 3'd2;
  localparam logic [2:0] ACT_DENY     = 3'd3;
  localparam logic [2:0] ACT_DISPATCH = 3'd4;
  localparam logic [2:0] ACT_SEND     = 3'd5;

  // fixed header bytes and ids
  localparam logic [7:0]  HDR_CAPS      = 8'h50;
  localparam logic [7:0]  HDR_SEND      = 8'h32;
  localparam logic [31:0] UNASSIGNED_ID = 32'hFFFF_FFFF;
  localparam logic [2:0]  SEND_ID_BYTES = 3'd4;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_REGISTER,
    OP_CAPS,
    OP_CREATE,
    OP_DATA,
    OP_CLOSE,
    OP_SEND,
    OP_UNHANDLED
  } op_e;

  // back part sequencer
  typedef enum logic [0:0] {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] name_hash;
    logic [7:0]  handler_tag;
    logic [7:0]  header_byte;
    logic [31:0] raw_channel_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  action;
    logic [7:0]  reply_header;
    logic [31:0] reply_channel_id;
    logic [2:0]  reply_id_bytes;
    logic [7:0]  dispatch_tag;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] name_hash;
    logic [7:0]  handler_tag;
    logic [7:0]  header_byte;
    logic [31:0] decoded_id;
    logic [2:0]  id_bytes;
  } cmd_t;

endpackage

// ===== sv/dynamic_channel_demux_table_top.sv =====
// dynamic_channel_demux_table_top: channel registration, PDU header handling
// and send header generation. Depends on dcdt_pkg, dcdt_front, dcdt_fifo, dcdt_back.
//
// Usage:
//   Requests enter through a queue-style port: req_i is taken at a rising edge
//   with push high and full low. Results leave the same way: rsp_o is valid
//   while empty is low and is taken at an edge with pop high.
//   Every request yields exactly one result, in request order.
// Path: a result passes the command queue, the latched lookup and the result
//   register (lookup, execute) when the back part is idle and the register is free.
// Overlap: the back part takes no new request from the queue until its last one
//   has finished the lookup-then-execute sequence over the channel table.
// Reset: the table is empty, both queues are empty, full and pop side idle.
// Stall: while a result waits, the back part holds its command; the command
//   queue keeps filling and full rises once it holds QueueDepth requests.
// The table keeps TableEntries channels, compared in parallel each lookup.
module dynamic_channel_demux_table_top #(
  parameter int unsigned TableEntries = dcdt_pkg::TableEntriesDefault,
  parameter int unsigned QueueDepth   = dcdt_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  dcdt_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output dcdt_pkg::rsp_t rsp_o
);
  import dcdt_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic cmd_empty;
  logic cmd_pop;

  // classify and decode
  dcdt_front u_front (
    .req_i (req_i),
    .cmd_o (front_cmd)
  );

  // decoupling queue
  dcdt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (head_cmd)
  );

  // table and execution
  dcdt_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== sv/dcdt_front.sv =====
// dcdt_front: classifies an incoming request and decodes its channel id.
// Depends on dcdt_pkg; feeds the command queue.
module dcdt_front (
  input  dcdt_pkg::req_t req_i,
  output dcdt_pkg::cmd_t cmd_o
);
  import dcdt_pkg::*;

  logic [3:0]  cmd;
  logic [1:0]  code;
  logic [31:0] id;
  logic [2:0]  nbytes;

  // header fields and id width decode
  always_comb begin
    cmd  = req_i.header_byte[7:4];
    code = req_i.header_byte[1:0];
    case (code)
      WIDTH_8: begin
        id     = {24'd0, req_i.raw_channel_id[7:0]};
        nbytes = 3'd1;
      end
      WIDTH_16: begin
        id     = {16'd0, req_i.raw_channel_id[15:0]};
        nbytes = 3'd2;
      end
      WIDTH_32: begin
        id     = req_i.raw_channel_id;
        nbytes = 3'd4;
      end
      default: begin
        id     = UNASSIGNED_ID;
        nbytes = 3'd4;
      end
    endcase
    // an unassigned id emits no id bytes
    if (id == UNASSIGNED_ID) begin
      nbytes = 3'd0;
    end
  end

  // operation classification
  always_comb begin
    cmd_o.name_hash   = req_i.name_hash;
    cmd_o.handler_tag = req_i.handler_tag;
    cmd_o.header_byte = req_i.header_byte;
    cmd_o.decoded_id  = id;
    cmd_o.id_bytes    = nbytes;
    case (req_i.kind)
      KIND_REGISTER: cmd_o.op = OP_REGISTER;
      KIND_SEND:     cmd_o.op = OP_SEND;
      KIND_PDU: begin
        case (cmd)
          CMD_CAPS:   cmd_o.op = OP_CAPS;
          CMD_CREATE: cmd_o.op = OP_CREATE;
          CMD_DATA:   cmd_o.op = OP_DATA;
          CMD_CLOSE:  cmd_o.op = OP_CLOSE;
          default:    cmd_o.op = OP_UNHANDLED;
        endcase
      end
      default: cmd_o.op = OP_UNHANDLED;
    endcase
  end

endmodule

// ===== sv/dcdt_fifo.sv =====
// dcdt_fifo: short command queue between the front and the back part.
// Depends on dcdt_pkg for the command type.
module dcdt_fifo #(
  parameter int unsigned Depth = dcdt_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcdt_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dcdt_pkg::cmd_t data_o
);
  import dcdt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/dcdt_back.sv =====
// dcdt_back: channel table, lookup and execution of queued commands.
// Depends on dcdt_pkg; takes commands from dcdt_fifo, drives the result register.
module dcdt_back #(
  parameter int unsigned TableEntries = dcdt_pkg::TableEntriesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  dcdt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output dcdt_pkg::rsp_t rsp_o
);
  import dcdt_pkg::*;

  localparam logic [TableEntries-1:0] OneVec = TableEntries'(1);

  back_state_e state_q, state_d;

  // table
  logic [TableEntries-1:0] valid_q;
  logic [31:0]             hash_q    [TableEntries];
  logic [31:0]             cid_q     [TableEntries];
  logic [7:0]              handler_q [TableEntries];

  // lookup results
  logic [TableEntries-1:0] hash_m, id_m, free_m;
  logic [TableEntries-1:0] hash_oh_d, id_oh_d, free_oh_d;
  logic [TableEntries-1:0] hash_oh_q, id_oh_q, free_oh_q;
  cmd_t                    cmd_q;

  // execution
  logic [31:0] hash_cid;
  logic [7:0]  id_handler;
  logic        fire;
  rsp_t        rsp_d;
  logic [TableEntries-1:0] set_oh, clr_oh, upd_oh;

  rsp_t out_q;
  logic out_valid_q;

  assign empty_o = !out_valid_q;
  assign rsp_o   = out_q;

  // parallel compare against the head command, first match wins
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hash_m[i] = valid_q[i] && (hash_q[i] == cmd_i.name_hash);
      id_m[i]   = valid_q[i] && (cid_q[i] == cmd_i.decoded_id);
      free_m[i] = !valid_q[i];
    end
    hash_oh_d = hash_m & (~hash_m + OneVec);
    id_oh_d   = id_m & (~id_m + OneVec);
    free_oh_d = free_m & (~free_m + OneVec);
  end

  // selected entry fields
  always_comb begin
    hash_cid   = '0;
    id_handler = '0;
    for (int i = 0; i < TableEntries; i++) begin
      hash_cid   = hash_cid | (hash_oh_q[i] ? cid_q[i] : 32'd0);
      id_handler = id_handler | (id_oh_q[i] ? handler_q[i] : 8'd0);
    end
  end

  // sequencer and result build
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    fire      = 1'b0;
    set_oh    = '0;
    clr_oh    = '0;
    upd_oh    = '0;
    rsp_d     = '0;

    case (cmd_q.op)
      OP_REGISTER: begin
        if (cmd_q.name_hash == 32'd0 || hash_oh_q != '0) begin
          rsp_d.status = ST_DUPLICATE;
        end else if (free_oh_q != '0) begin
          rsp_d.status = ST_OK;
          set_oh       = free_oh_q;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      OP_CAPS: begin
        rsp_d.action       = ACT_CAPS;
        rsp_d.reply_header = HDR_CAPS;
      end
      OP_CREATE: begin
        rsp_d.reply_header     = cmd_q.header_byte;
        rsp_d.reply_channel_id = cmd_q.decoded_id;
        rsp_d.reply_id_bytes   = cmd_q.id_bytes;
        if (hash_oh_q != '0) begin
          rsp_d.action = ACT_GRANT;
          upd_oh       = hash_oh_q;
        end else begin
          rsp_d.status = ST_UNKNOWN;
          rsp_d.action = ACT_DENY;
        end
      end
      OP_DATA: begin
        rsp_d.reply_channel_id = cmd_q.decoded_id;
        if (id_oh_q != '0) begin
          rsp_d.action       = ACT_DISPATCH;
          rsp_d.dispatch_tag = id_handler;
        end else begin
          rsp_d.status = ST_UNKNOWN;
        end
      end
      OP_CLOSE: begin
        rsp_d.reply_channel_id = cmd_q.decoded_id;
        if (id_oh_q != '0) begin
          clr_oh = id_oh_q;
        end else begin
          rsp_d.status = ST_UNKNOWN;
        end
      end
      OP_SEND: begin
        if (hash_oh_q != '0 && hash_cid != UNASSIGNED_ID) begin
          rsp_d.action           = ACT_SEND;
          rsp_d.reply_header     = HDR_SEND;
          rsp_d.reply_channel_id = hash_cid;
          rsp_d.reply_id_bytes   = SEND_ID_BYTES;
        end else begin
          rsp_d.status = ST_UNKNOWN;
        end
      end
      default: begin
        rsp_d.status = ST_UNHANDLED;
      end
    endcase

    case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          state_d   = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid_q || pop_i) begin
          fire    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase

    if (!fire) begin
      set_oh = '0;
      clr_oh = '0;
      upd_oh = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (valid_q | set_oh) & ~clr_oh;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // latched command and lookup results
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q     <= cmd_i;
      hash_oh_q <= hash_oh_d;
      id_oh_q   <= id_oh_d;
      free_oh_q <= free_oh_d;
    end
    if (fire) begin
      out_q <= rsp_d;
    end
  end

  // table entry writes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TableEntries; i++) begin
      if (set_oh[i]) begin
        hash_q[i]    <= cmd_q.name_hash;
        cid_q[i]     <= UNASSIGNED_ID;
        handler_q[i] <= cmd_q.handler_tag;
      end else if (upd_oh[i]) begin
        cid_q[i] <= cmd_q.decoded_id;
      end
    end
  end

endmodule

// ===== tb/tb_dynamic_channel_demux_table_top.sv =====
// tb_dynamic_channel_demux_table_top: self-checking bench for the channel demux table.
// Depends on dcdt_pkg and dynamic_channel_demux_table_top; results are predicted locally
// from a shadow copy of the channel table and checked in request order.
module tb_dynamic_channel_demux_table_top;
  import dcdt_pkg::*;

  localparam int unsigned NumEntries = TableEntriesDefault;
  localparam int unsigned HashPool   = 24;
  localparam int unsigned IdPool     = 8;
  localparam int unsigned MaxReports = 30;

  // header values that fall outside the handled command set
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [3:0] CMD_RSVD_LO = 4'h0;
  localparam logic [3:0] CMD_RSVD_HI = 4'hF;
  localparam logic [1:0] WIDTH_NONE  = 2'd3;

  typedef struct {
    req_t req;
    bit   known;
    rsp_t rsp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  req_t req_i;
  logic empty;
  logic pop;
  rsp_t rsp_o;

  // shadow channel table
  logic [31:0] tbl_hash [NumEntries];
  logic [31:0] tbl_id   [NumEntries];
  logic [7:0]  tbl_tag  [NumEntries];

  rsp_t        pending_rsp [$];
  dir_row_t    dir_rows [$];
  logic [31:0] hash_pool [HashPool];
  logic [31:0] id_pool   [IdPool];

  bit tx_idle_on;
  bit rx_idle_on;
  int n_errors;
  int n_requests;
  int n_results;
  int n_full;
  int n_dispatch;
  int n_sends;

  dynamic_channel_demux_table_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // clear the shadow table at the start of the run
  initial begin
    for (int i = 0; i < NumEntries; i++) begin
      tbl_hash[i] = '0;
      tbl_id[i]   = '0;
      tbl_tag[i]  = '0;
    end
  end

  // first live slot holding a name, zero names never match
  function automatic int hash_slot(input logic [31:0] h);
    int i;
    hash_slot = -1;
    if (h != '0) begin
      for (i = NumEntries - 1; i >= 0; i--) begin
        if (tbl_hash[i] == h) hash_slot = i;
      end
    end
  endfunction

  // first live slot holding an id, free slots are skipped
  function automatic int id_slot(input logic [31:0] id);
    int i;
    id_slot = -1;
    for (i = NumEntries - 1; i >= 0; i--) begin
      if (tbl_hash[i] != '0 && tbl_id[i] == id) id_slot = i;
    end
  endfunction

  // outcome of one request, applied to the shadow table
  function automatic rsp_t demux_outcome(input req_t r);
    rsp_t        o;
    int          slot;
    int          i;
    logic [3:0]  cmd;
    logic [1:0]  code;
    logic [31:0] id;
    o    = '0;
    cmd  = r.header_byte[7:4];
    code = r.header_byte[1:0];
    case (code)
      WIDTH_8:  id = {24'd0, r.raw_channel_id[7:0]};
      WIDTH_16: id = {16'd0, r.raw_channel_id[15:0]};
      WIDTH_32: id = r.raw_channel_id;
      default:  id = UNASSIGNED_ID;
    endcase
    case (r.kind)
      KIND_REGISTER: begin
        if (r.name_hash == '0 || hash_slot(r.name_hash) >= 0) begin
          o.status = ST_DUPLICATE;
        end else begin
          slot = -1;
          for (i = NumEntries - 1; i >= 0; i--) begin
            if (tbl_hash[i] == '0) slot = i;
          end
          if (slot < 0) begin
            o.status = ST_FULL;
          end else begin
            tbl_hash[slot] = r.name_hash;
            tbl_id[slot]   = UNASSIGNED_ID;
            tbl_tag[slot]  = r.handler_tag;
            o.status       = ST_OK;
          end
        end
      end
      KIND_PDU: begin
        case (cmd)
          CMD_CAPS: begin
            o.action       = ACT_CAPS;
            o.reply_header = HDR_CAPS;
          end
          CMD_CREATE: begin
            slot               = hash_slot(r.name_hash);
            o.reply_header     = r.header_byte;
            o.reply_channel_id = id;
            if (id != UNASSIGNED_ID) begin
              o.reply_id_bytes = (code == WIDTH_8) ? 3'd1 : (code == WIDTH_16) ? 3'd2 : 3'd4;
            end
            if (slot >= 0) begin
              tbl_id[slot] = id;
              o.action     = ACT_GRANT;
            end else begin
              o.status = ST_UNKNOWN;
              o.action = ACT_DENY;
            end
          end
          CMD_DATA: begin
            slot               = id_slot(id);
            o.reply_channel_id = id;
            if (slot >= 0) begin
              o.action       = ACT_DISPATCH;
              o.dispatch_tag = tbl_tag[slot];
            end else begin
              o.status = ST_UNKNOWN;
            end
          end
          CMD_CLOSE: begin
            slot               = id_slot(id);
            o.reply_channel_id = id;
            if (slot >= 0) begin
              tbl_hash[slot] = '0;
              tbl_id[slot]   = '0;
              tbl_tag[slot]  = '0;
            end else begin
              o.status = ST_UNKNOWN;
            end
          end
          default: o.status = ST_UNHANDLED;
        endcase
      end
      KIND_SEND: begin
        slot = hash_slot(r.name_hash);
        if (slot >= 0 && tbl_id[slot] != UNASSIGNED_ID) begin
          o.action           = ACT_SEND;
          o.reply_header     = HDR_SEND;
          o.reply_channel_id = tbl_id[slot];
          o.reply_id_bytes   = SEND_ID_BYTES;
        end else begin
          o.status = ST_UNKNOWN;
        end
      end
      default: o.status = ST_UNHANDLED;
    endcase
    return o;
  endfunction

  // random request, mostly well-formed traffic over small name and id pools
  function automatic req_t random_request(input int reg_weight);
    req_t        r;
    int          pick;
    logic [31:0] id;
    logic [31:0] noise;
    logic [31:0] raw;
    logic [1:0]  code;
    logic [3:0]  cmd;
    r.kind        = KIND_PDU;
    r.name_hash   = hash_pool[$urandom_range(0, HashPool - 1)];
    r.handler_tag = 8'($urandom);
    noise         = $urandom;
    id            = id_pool[$urandom_range(0, IdPool - 1)];
    // pick a width that keeps the id intact, now and then the unassigned code
    if ($urandom_range(0, 9) == 0) code = WIDTH_NONE;
    else if (id[31:16] != '0) code = WIDTH_32;
    else if (id[15:8] != '0) code = $urandom_range(0, 1) ? WIDTH_16 : WIDTH_32;
    else code = 2'($urandom_range(WIDTH_8, WIDTH_32));
    case (code)
      WIDTH_8:  raw = {noise[31:8], id[7:0]};
      WIDTH_16: raw = {noise[31:16], id[15:0]};
      WIDTH_32: raw = id;
      default:  raw = noise;
    endcase
    cmd  = CMD_CAPS;
    pick = $urandom_range(0, 99);
    if (pick < reg_weight) begin
      r.kind = KIND_REGISTER;
      if ($urandom_range(0, 19) == 0) r.name_hash = '0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_CREATE;
      else if (pick < 60) cmd = CMD_DATA;
      else if (pick < 72) cmd = CMD_CLOSE;
      else if (pick < 88) r.kind = KIND_SEND;
      else if (pick < 93) cmd = CMD_CAPS;
      else begin
        // unconstrained noise
        r.kind      = 2'($urandom);
        r.name_hash = $urandom;
        code        = 2'($urandom);
        cmd         = 4'($urandom);
        raw         = $urandom;
      end
      if (cmd == CMD_CREATE && $urandom_range(0, 9) == 0) r.name_hash = $urandom;
    end
    r.header_byte    = {cmd, 2'($urandom), code};
    r.raw_channel_id = raw;
    return r;
  endfunction

  task automatic dir_row(input logic [1:0] k, input logic [31:0] h, input logic [7:0] t,
                         input logic [7:0] hb, input logic [31:0] raw);
    dir_row_t d;
    d.req.kind           = k;
    d.req.name_hash      = h;
    d.req.handler_tag    = t;
    d.req.header_byte    = hb;
    d.req.raw_channel_id = raw;
    d.known              = 1'b0;
    d.rsp                = '0;
    dir_rows.push_back(d);
  endtask

  // pin the result of the last directed row
  task automatic dir_known(input logic [2:0] st, input logic [2:0] act, input logic [7:0] rh,
                           input logic [31:0] rid, input logic [2:0] rb, input logic [7:0] dt);
    dir_row_t d;
    d                      = dir_rows.pop_back();
    d.known                = 1'b1;
    d.rsp.status           = st;
    d.rsp.action           = act;
    d.rsp.reply_header     = rh;
    d.rsp.reply_channel_id = rid;
    d.rsp.reply_id_bytes   = rb;
    d.rsp.dispatch_tag     = dt;
    dir_rows.push_back(d);
  endtask

  // present one request and wait until it is taken
  task automatic issue_request(input req_t r, input bit known, input rsp_t pinned);
    int   gap;
    rsp_t predicted;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full !== 1'b0);
    predicted = demux_outcome(r);
    pending_rsp.push_back(known ? pinned : predicted);
    n_requests++;
  endtask

  // hold off new requests until every result is back
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
  endtask

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] seen);
    n_errors++;
    if (n_errors <= MaxReports) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
    end
  endtask

  // result side: random pop gaps, field by field compare
  initial begin : result_sink
    int   gap;
    rsp_t want;
    pop = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      n_results++;
      if (rsp_o.status == ST_FULL) n_full++;
      if (rsp_o.action == ACT_DISPATCH) n_dispatch++;
      if (rsp_o.action == ACT_SEND) n_sends++;
      if (pending_rsp.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) begin
          $display("%0t: unexpected result, expected none actual %h", $time, rsp_o);
        end
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status)
          flag_field("status", 32'(want.status), 32'(rsp_o.status));
        if (rsp_o.action !== want.action)
          flag_field("action", 32'(want.action), 32'(rsp_o.action));
        if (rsp_o.reply_header !== want.reply_header)
          flag_field("reply_header", 32'(want.reply_header), 32'(rsp_o.reply_header));
        if (rsp_o.reply_channel_id !== want.reply_channel_id)
          flag_field("reply_channel_id", want.reply_channel_id, rsp_o.reply_channel_id);
        if (rsp_o.reply_id_bytes !== want.reply_id_bytes)
          flag_field("reply_id_bytes", 32'(want.reply_id_bytes), 32'(rsp_o.reply_id_bytes));
        if (rsp_o.dispatch_tag !== want.dispatch_tag)
          flag_field("dispatch_tag", 32'(want.dispatch_tag), 32'(rsp_o.dispatch_tag));
      end
    end
  end

  // request side: directed rows, then random rounds
  initial begin : stimulus
    int reg_weight;
    rst_ni     = 1'b0;
    push       = 1'b0;
    req_i      = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    n_errors   = 0;
    n_requests = 0;
    n_results  = 0;
    n_full     = 0;
    n_dispatch = 0;
    n_sends    = 0;

    // name and id pools, ids spread over the three widths
    for (int i = 0; i < HashPool; i++) begin
      do hash_pool[i] = $urandom; while (hash_pool[i] == '0);
    end
    for (int i = 0; i < IdPool; i++) begin
      if (i < 2) id_pool[i] = $urandom_range(0, 255);
      else if (i < 4) id_pool[i] = $urandom_range(256, 65535);
      else id_pool[i] = $urandom;
    end

    // empty table, unused kind and unhandled commands
    dir_row(KIND_SEND, 32'h0000_1234, 8'h00, 8'h00, 32'h0);
    dir_known(ST_UNKNOWN, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    dir_row(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    dir_known(ST_UNHANDLED, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    // id zero must not hit a free slot
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_DATA, 2'b00, WIDTH_8}, 32'h0);
    dir_known(ST_UNKNOWN, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_CAPS, 2'b11, WIDTH_NONE}, 32'hFFFF_FFFF);
    dir_known(ST_OK, ACT_CAPS, HDR_CAPS, 32'h0, 3'd0, 8'h00);
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_RSVD_HI, 2'b11, WIDTH_NONE}, 32'h0);
    dir_known(ST_UNHANDLED, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_RSVD_LO, 2'b00, WIDTH_8}, 32'h0);
    dir_known(ST_UNHANDLED, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    // zero name, first name, duplicate
    dir_row(KIND_REGISTER, 32'h0, 8'hAA, 8'h00, 32'h0);
    dir_known(ST_DUPLICATE, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    dir_row(KIND_REGISTER, 32'hFFFF_FFFF, 8'hFF, 8'h00, 32'h0);
    dir_known(ST_OK, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    dir_row(KIND_REGISTER, 32'hFFFF_FFFF, 8'h11, 8'h00, 32'h0);
    dir_known(ST_DUPLICATE, ACT_NONE, 8'h00, 32'h0, 3'd0, 8'h00);
    // unassigned id matches through width code three
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_DATA, 2'b00, WIDTH_NONE}, 32'h0);
    dir_row(KIND_SEND, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'h0);
    // create with zero name is denied
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_CREATE, 2'b00, WIDTH_32}, 32'hFFFF_FFFF);
    dir_known(ST_UNKNOWN, ACT_DENY, {CMD_CREATE, 2'b00, WIDTH_32}, UNASSIGNED_ID, 3'd0, 8'h00);
    dir_row(KIND_PDU, 32'hFFFF_FFFF, 8'h00, {CMD_CREATE, 2'b01, WIDTH_8}, 32'hABCD_EF12);
    dir_row(KIND_SEND, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'h0);
    dir_row(KIND_REGISTER, 32'h0000_0001, 8'h00, 8'h00, 32'h0);
    dir_row(KIND_PDU, 32'h0000_0001, 8'h00, {CMD_CREATE, 2'b11, WIDTH_16}, 32'hFFFF_1234);
    dir_row(KIND_PDU, 32'h0000_0005, 8'h00, {CMD_CREATE, 2'b10, WIDTH_NONE}, 32'h0);
    // dispatch by the 16 and 32 bit widths, then an unknown 8 bit id
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_DATA, 2'b00, WIDTH_16}, 32'h0000_1234);
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_DATA, 2'b10, WIDTH_32}, 32'h0000_0012);
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_DATA, 2'b01, WIDTH_8}, 32'hFFFF_FF77);
    // close, close again, send to the closed name
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_CLOSE, 2'b00, WIDTH_8}, 32'h5A5A_5A12);
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_CLOSE, 2'b00, WIDTH_8}, 32'h5A5A_5A12);
    dir_row(KIND_SEND, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'h0);
    // a 32 bit create of the unassigned id emits no id bytes
    dir_row(KIND_PDU, 32'h0000_0001, 8'h00, {CMD_CREATE, 2'b00, WIDTH_32}, 32'hFFFF_FFFF);
    dir_row(KIND_PDU, 32'h0, 8'h00, {CMD_CLOSE, 2'b00, WIDTH_NONE}, 32'h0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);
    wait_drained();

    // random rounds with changing registration pressure and idling
    for (int round = 0; round < 12; round++) begin
      tx_idle_on = (round % 3) != 0;
      rx_idle_on = (round % 4) != 1;
      reg_weight = (round == 0) ? 70 : $urandom_range(5, 60);
      repeat (100) issue_request(random_request(reg_weight), 1'b0, '0);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d requests and %0d results checked", n_requests, n_results);
    $display("full table refusals %0d, dispatches %0d, send headers %0d",
             n_full, n_dispatch, n_sends);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
